### rtl/lbsf_pkg.sv
// ============================================================================
// lbsf_pkg: shared types and constants of the label run singleton filter
// Field widths, the mark encoding and the decided-entry record passed from
// the window to the drop counter stage.
// ============================================================================
package lbsf_pkg;

    // fixed field widths
    localparam int KEY_FIELD_W = 48;
    localparam int CLASS_W     = 12;
    localparam int COUNT_W     = 32;
    localparam int WIN         = 4;

    // widest class range the counter memory may cover, plus one bit
    localparam int RANGE_W     = 17;

    // entry marks
    typedef enum logic [1:0] {
        MARK_SINGLE    = 2'd0,
        MARK_CLUSTER   = 2'd1,
        MARK_BRIDGED   = 2'd2,
        MARK_CROSSOVER = 2'd3
    } t_mark;

    // one decided entry on its way to the counter stage
    typedef struct packed {
        logic [KEY_FIELD_W-1:0] key;
        logic [CLASS_W-1:0]     cls;
        logic                   keep;
        logic                   last;
    } t_decided;

endpackage

### rtl/label_run_singleton_filter_top.sv
// ============================================================================
// label_run_singleton_filter_top: label run singleton filter
// Marks each entry of a sorted, class-labeled list from a four-entry window
// and keeps per-class saturating drop counters in memory.
// ============================================================================
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  -----------------------------
//  in        input      i_in_valid/o_in_stall   key, class, end of list
//  out       output     o_out_valid/i_out_stall key, class, kept, count, last
//
//  one request per cycle while a list runs and nothing stalls; a request that
//  ends a list holding n entries (1..4 with the new one) releases them one per
//  cycle while the counter is ready, as the window releases only its head
//  results pass through the read stage and the output register after the
//  release of their entry; after reset the counter memory is cleared, during
//  which no request is taken
//  a stall on the output backs up through the read stage to o_in_stall
//
module label_run_singleton_filter_top
    import lbsf_pkg::*;
#(
    parameter int CLASS_COUNT = 4096,
    parameter int KEY_BITS    = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [KEY_FIELD_W-1:0] i_entry_key,
    input  logic [CLASS_W-1:0]     i_entry_class,
    input  logic                   i_end_of_list,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [KEY_FIELD_W-1:0] o_out_key,
    output logic [CLASS_W-1:0]     o_out_class,
    output logic                   o_kept,
    output logic [COUNT_W-1:0]     o_drop_count,
    output logic                   o_last_of_list
);

    logic     emit_valid;
    logic     emit_ready;
    t_decided emit;

    // marking window
    lbsf_window #(
        .KEY_BITS (KEY_BITS)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_entry_key   (i_entry_key),
        .i_entry_class (i_entry_class),
        .i_end_of_list (i_end_of_list),
        .i_emit_ready  (emit_ready),
        .o_emit_valid  (emit_valid),
        .o_emit        (emit)
    );

    // drop counters and output register
    lbsf_counter #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_counter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit_valid   (emit_valid),
        .i_emit         (emit),
        .o_emit_ready   (emit_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_key      (o_out_key),
        .o_out_class    (o_out_class),
        .o_kept         (o_kept),
        .o_drop_count   (o_drop_count),
        .o_last_of_list (o_last_of_list)
    );

endmodule

### rtl/lbsf_window.sv
// ============================================================================
// lbsf_window: four-entry window that marks and releases list entries
// Inserts each request at the fill point, decides the head mark over the
// entries present and shifts it out when the window is full or a list ends,
// then drains the remaining entries one per cycle while the counter is ready.
// ============================================================================
module lbsf_window
    import lbsf_pkg::*;
#(
    parameter int KEY_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [KEY_FIELD_W-1:0] i_entry_key,
    input  logic [CLASS_W-1:0]     i_entry_class,
    input  logic                   i_end_of_list,
    input  logic                   i_emit_ready,
    output logic                   o_emit_valid,
    output t_decided               o_emit
);

    localparam int KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;

    logic [KEY_W-1:0]   r_key [WIN];
    logic [CLASS_W-1:0] r_cls [WIN];
    t_mark              r_mark [WIN];
    logic [1:0]         r_fill;
    logic               r_flush;

    logic [KEY_W-1:0]   w_key [WIN];
    logic [CLASS_W-1:0] w_cls [WIN];
    t_mark              w_mark [WIN];
    t_mark              d_mark [WIN];
    logic [2:0]         w_fill;

    logic [KEY_W-1:0]   n_key [WIN];
    logic [CLASS_W-1:0] n_cls [WIN];
    t_mark              n_mark [WIN];
    logic [1:0]         n_fill;
    logic               n_flush;

    logic               accept;
    logic               eol;
    logic               emit;

    // request handshake; draining blocks new requests
    assign o_in_stall = r_flush || !i_emit_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign eol        = accept && i_end_of_list;

    // window with the new entry placed at the fill point
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            if (accept && (r_fill == 2'(i))) begin
                w_key[i]  = i_entry_key[KEY_W-1:0];
                w_cls[i]  = i_entry_class;
                w_mark[i] = MARK_SINGLE;
            end else begin
                w_key[i]  = r_key[i];
                w_cls[i]  = r_cls[i];
                w_mark[i] = r_mark[i];
            end
        end
        w_fill = {1'b0, r_fill} + 3'(accept);
    end

    // head release: full window, end of list, or draining
    assign emit = r_flush ? i_emit_ready
                          : (accept && ((w_fill == 3'd4) || i_end_of_list));

    // head decision over the entries present
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            d_mark[i] = w_mark[i];
        end
        if ((w_fill > 3'd1) && (w_cls[0] == w_cls[1])) begin
            d_mark[0] = MARK_CLUSTER;
            d_mark[1] = MARK_CLUSTER;
        end else if ((w_fill > 3'd2) && (w_cls[0] == w_cls[2])) begin
            if ((w_mark[1] == MARK_BRIDGED) || (w_mark[1] == MARK_CROSSOVER)) begin
                d_mark[0] = MARK_CROSSOVER;
                d_mark[1] = MARK_CROSSOVER;
                d_mark[2] = MARK_CROSSOVER;
            end else if ((w_fill > 3'd3) && (w_mark[0] != MARK_CLUSTER)
                         && (w_cls[1] == w_cls[3])) begin
                d_mark[0] = MARK_CROSSOVER;
                d_mark[1] = MARK_CROSSOVER;
                d_mark[2] = MARK_CROSSOVER;
                d_mark[3] = MARK_CROSSOVER;
            end else begin
                if ((w_mark[0] != MARK_CLUSTER) && (w_mark[0] != MARK_CROSSOVER)) begin
                    d_mark[0] = MARK_BRIDGED;
                end
                d_mark[2] = MARK_BRIDGED;
            end
        end
    end

    // released entry
    assign o_emit_valid = emit;
    always_comb begin
        o_emit.key  = KEY_FIELD_W'(w_key[0]);
        o_emit.cls  = w_cls[0];
        o_emit.keep = (d_mark[0] == MARK_CLUSTER) || (d_mark[0] == MARK_BRIDGED);
        o_emit.last = (r_flush || eol) && (w_fill == 3'd1);
    end

    // next window: shift down after a release
    always_comb begin
        if (emit) begin
            for (int i = 0; i < WIN - 1; i++) begin
                n_key[i]  = w_key[i+1];
                n_cls[i]  = w_cls[i+1];
                n_mark[i] = d_mark[i+1];
            end
            n_key[WIN-1]  = '0;
            n_cls[WIN-1]  = '0;
            n_mark[WIN-1] = MARK_SINGLE;
            n_fill        = 2'(w_fill - 3'd1);
            n_flush       = (r_flush || eol) && (w_fill != 3'd1);
        end else begin
            for (int i = 0; i < WIN; i++) begin
                n_key[i]  = w_key[i];
                n_cls[i]  = w_cls[i];
                n_mark[i] = w_mark[i];
            end
            n_fill  = w_fill[1:0];
            n_flush = r_flush;
        end
    end

    // window registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WIN; i++) begin
            r_key[i]  <= n_key[i];
            r_cls[i]  <= n_cls[i];
            r_mark[i] <= n_mark[i];
        end
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_flush <= n_flush;
        end
    end

`ifndef SYNTHESIS
    // draining always has entries left
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_fill != 2'd0))
        else $error("window draining with no entries");

    // an end-of-list request leaves either a drain or an empty window
    a_eol_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eol |=> (r_flush || (r_fill == 2'd0)))
        else $error("end of list left entries without a drain");

    // a full window always releases its head
    a_full_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (w_fill == 3'd4)) |-> emit)
        else $error("full window did not release its head");
`endif

endmodule

### rtl/lbsf_counter.sv
// ============================================================================
// lbsf_counter: per-class drop counters in a synchronous memory
// Reads the counter of each decided entry, bumps it for a dropped entry with
// saturation, writes it back with forwarding, and holds the result in an
// output register. Clears the memory after reset.
// ============================================================================
module lbsf_counter
    import lbsf_pkg::*;
#(
    parameter int CLASS_COUNT = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_emit_valid,
    input  t_decided               i_emit,
    output logic                   o_emit_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [KEY_FIELD_W-1:0] o_out_key,
    output logic [CLASS_W-1:0]     o_out_class,
    output logic                   o_kept,
    output logic [COUNT_W-1:0]     o_drop_count,
    output logic                   o_last_of_list
);

    localparam int ADDR_W = $clog2(CLASS_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CLASS_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [COUNT_W-1:0] mem [CLASS_COUNT];

    // clearing pass
    logic               r_clr_active;
    logic [ADDR_W-1:0]  r_clr_addr;

    // read stage
    logic               r_s1_valid;
    t_decided           r_s1;
    logic               r_s1_in_range;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [COUNT_W-1:0] r_rd_data;

    // last counter write, for forwarding
    logic               r_wr_valid;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic [COUNT_W-1:0] r_wr_data;

    // output register
    logic               r_out_valid;
    t_decided           r_out;
    logic [COUNT_W-1:0] r_out_count;

    logic [RANGE_W-1:0] cls_ext;
    logic               in_range;
    logic [ADDR_W-1:0]  rd_addr;
    logic               out_ready;
    logic               s1_load;
    logic               s1_adv;
    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] new_count;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;

    // flow control
    assign out_ready    = !r_out_valid || !i_out_stall;
    assign s1_adv       = r_s1_valid && out_ready;
    assign o_emit_ready = !r_clr_active && (!r_s1_valid || out_ready);
    assign s1_load      = i_emit_valid && o_emit_ready;

    // class to counter address
    assign cls_ext  = RANGE_W'(i_emit.cls);
    assign in_range = cls_ext < RANGE_W'(CLASS_COUNT);
    assign rd_addr  = cls_ext[ADDR_W-1:0];

    // counter update with forwarding from the previous write
    always_comb begin
        if (r_wr_valid && (r_wr_addr == r_s1_addr)) begin
            base_count = r_wr_data;
        end else begin
            base_count = r_rd_data;
        end
        if (!r_s1_in_range) begin
            new_count = '0;
        end else if (r_s1.keep || (base_count == COUNT_MAX)) begin
            new_count = base_count;
        end else begin
            new_count = base_count + 1'b1;
        end
    end

    // single write port: clearing pass or counter write-back
    assign wr_en   = r_clr_active || (s1_adv && r_s1_in_range);
    assign wr_addr = r_clr_active ? r_clr_addr : r_s1_addr;
    assign wr_data = r_clr_active ? '0 : new_count;

    // counter memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (s1_load) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1          <= i_emit;
            r_s1_in_range <= in_range;
            r_s1_addr     <= rd_addr;
        end
        if (s1_adv) begin
            r_out       <= r_s1;
            r_out_count <= new_count;
            r_wr_addr   <= r_s1_addr;
            r_wr_data   <= new_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_wr_valid   <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_wr_valid  <= r_s1_in_range;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_key      = r_out.key;
    assign o_out_class    = r_out.cls;
    assign o_kept         = r_out.keep;
    assign o_drop_count   = r_out_count;
    assign o_last_of_list = r_out.last;

`ifndef SYNTHESIS
    // nothing enters the read stage while the memory is being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!r_s1_valid && !s1_load))
        else $error("request taken during counter clearing");

    // a class without a counter reports zero
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !r_s1_in_range) |=> (o_drop_count == '0))
        else $error("out-of-range class reported a nonzero count");

    // a kept entry leaves its counter unchanged
    a_kept_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1.keep) |-> (new_count == base_count || !r_s1_in_range))
        else $error("kept entry changed its counter");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench of the label run singleton filter
// Sends sorted class-labeled lists, predicts the keep decision and per-class
// drop counters of every entry and compares each result in list order.
// ============================================================================
module tb;
    import lbsf_pkg::*;

    localparam int N_CLASSES   = 4096;
    localparam int N_KEY_BITS  = 48;
    localparam int RAND_ITEMS  = 232;
    localparam int TAIL_CYCLES = 20;

    // one decided entry as it should leave the block
    typedef struct {
        logic [KEY_FIELD_W-1:0] key;
        logic [CLASS_W-1:0]     cls;
        logic                   kept;
        logic [COUNT_W-1:0]     count;
        logic                   last;
    } t_entry_result;

    typedef logic [CLASS_W-1:0] t_class_list[$];

    // window predictor and store of expected decisions
    class filter_scoreboard;
        logic [KEY_FIELD_W-1:0] win_key[WIN];
        logic [CLASS_W-1:0]     win_cls[WIN];
        t_mark                  win_mark[WIN];
        int unsigned            fill;
        logic [COUNT_W-1:0]     drop_cnt[N_CLASSES];
        t_entry_result          pending[$];
        int unsigned            errors;
        int unsigned            n_requests;
        int unsigned            n_results;
        int unsigned            n_kept;

        function new();
            foreach (win_key[i]) begin
                win_key[i]  = '0;
                win_cls[i]  = '0;
                win_mark[i] = MARK_SINGLE;
            end
            foreach (drop_cnt[i]) drop_cnt[i] = '0;
            fill       = 0;
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            n_kept     = 0;
        endfunction

        // settle the mark of the head entry from the entries present
        function void decide_head(int unsigned m);
            if (m > 1 && win_cls[0] == win_cls[1]) begin
                win_mark[0] = MARK_CLUSTER;
                win_mark[1] = MARK_CLUSTER;
            end else if (m > 2 && win_cls[0] == win_cls[2]) begin
                if (win_mark[1] == MARK_BRIDGED || win_mark[1] == MARK_CROSSOVER) begin
                    win_mark[0] = MARK_CROSSOVER;
                    win_mark[1] = MARK_CROSSOVER;
                    win_mark[2] = MARK_CROSSOVER;
                end else if (m > 3 && win_mark[0] != MARK_CLUSTER &&
                             win_cls[1] == win_cls[3]) begin
                    for (int i = 0; i < WIN; i++) win_mark[i] = MARK_CROSSOVER;
                end else begin
                    if (win_mark[0] != MARK_CLUSTER && win_mark[0] != MARK_CROSSOVER)
                        win_mark[0] = MARK_BRIDGED;
                    win_mark[2] = MARK_BRIDGED;
                end
            end
        endfunction

        // decide the head, update its drop counter and shift the window
        function void release_head(logic last);
            t_entry_result r;
            decide_head(fill);
            r.key   = win_key[0];
            r.cls   = win_cls[0];
            r.kept  = (win_mark[0] == MARK_CLUSTER || win_mark[0] == MARK_BRIDGED);
            r.count = '0;
            r.last  = last;
            if (int'(win_cls[0]) < N_CLASSES) begin
                if (!r.kept && drop_cnt[win_cls[0]] != '1)
                    drop_cnt[win_cls[0]] = drop_cnt[win_cls[0]] + 1;
                r.count = drop_cnt[win_cls[0]];
            end
            pending.push_back(r);
            for (int i = 0; i + 1 < WIN; i++) begin
                win_key[i]  = win_key[i+1];
                win_cls[i]  = win_cls[i+1];
                win_mark[i] = win_mark[i+1];
            end
            win_key[WIN-1]  = '0;
            win_cls[WIN-1]  = '0;
            win_mark[WIN-1] = MARK_SINGLE;
            fill--;
        endfunction

        // accepted request: enter it and release what it completes
        function void note_request(logic [KEY_FIELD_W-1:0] key, logic [CLASS_W-1:0] cls,
                                   logic eol);
            n_requests++;
            win_key[fill]  = KEY_FIELD_W'(64'(key) & ((64'd1 << N_KEY_BITS) - 64'd1));
            win_cls[fill]  = cls;
            win_mark[fill] = MARK_SINGLE;
            fill++;
            if (fill == WIN) release_head(1'b0);
            if (eol) begin
                while (fill > 0) release_head(fill == 1);
            end
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // accepted result: compare with the oldest expected decision
        function void check_result(logic [KEY_FIELD_W-1:0] key, logic [CLASS_W-1:0] cls,
                                   logic kept, logic [COUNT_W-1:0] count, logic last);
            t_entry_result r;
            if (pending.size() == 0) begin
                $error("unexpected result: key %0h class %0h", key, cls);
                errors++;
            end else begin
                r = pending.pop_front();
                n_results++;
                if (r.kept) n_kept++;
                cmp_field("out_key", 64'(r.key), 64'(key));
                cmp_field("out_class", 64'(r.cls), 64'(cls));
                cmp_field("kept", 64'(r.kept), 64'(kept));
                cmp_field("drop_count", 64'(r.count), 64'(count));
                cmp_field("last_of_list", 64'(r.last), 64'(last));
            end
        endfunction
    endclass

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [KEY_FIELD_W-1:0] i_entry_key    = '0;
    logic [CLASS_W-1:0]     i_entry_class  = '0;
    logic                   i_end_of_list  = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [KEY_FIELD_W-1:0] o_out_key;
    logic [CLASS_W-1:0]     o_out_class;
    logic                   o_kept;
    logic [COUNT_W-1:0]     o_drop_count;
    logic                   o_last_of_list;

    filter_scoreboard sb = new();
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned n_lists   = 0;

    label_run_singleton_filter_top #(
        .CLASS_COUNT (N_CLASSES),
        .KEY_BITS    (N_KEY_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_entry_key    (i_entry_key),
        .i_entry_class  (i_entry_class),
        .i_end_of_list  (i_end_of_list),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_key      (o_out_key),
        .o_out_class    (o_out_class),
        .o_kept         (o_kept),
        .o_drop_count   (o_drop_count),
        .o_last_of_list (o_last_of_list)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_entry_key, i_entry_class, i_end_of_list);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_key, o_out_class, o_kept, o_drop_count,
                                o_last_of_list);
        end
    end

    // present one request, with a random gap ahead of it, and wait until taken
    task automatic send_request(input logic [KEY_FIELD_W-1:0] key,
                                input logic [CLASS_W-1:0] cls, input logic eol);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_entry_key   <= key;
        i_entry_class <= cls;
        i_end_of_list <= eol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // one whole list with random keys
    task automatic send_list(input t_class_list classes);
        for (int i = 0; i < classes.size(); i++)
            send_request(KEY_FIELD_W'({$urandom, $urandom}), classes[i],
                         i == classes.size() - 1);
        n_lists++;
    endtask

    // random list: mostly from a small class alphabet, sometimes noise
    task automatic send_random_list(output int unsigned len);
        t_class_list            classes;
        logic [CLASS_W-1:0]     alpha[3];
        int unsigned            mode;
        int unsigned            n_alpha;
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 10);
        mode = $urandom_range(0, 9);
        n_alpha = $urandom_range(2, 3);
        foreach (alpha[i]) alpha[i] = CLASS_W'($urandom_range(0, 4095));
        for (int i = 0; i < len; i++) begin
            if (mode < 7)
                classes.push_back(alpha[$urandom_range(0, n_alpha - 1)]);
            else if (mode < 9)
                classes.push_back(CLASS_W'($urandom_range(0, 4095)));
            else
                classes.push_back(alpha[0]);
        end
        send_list(classes);
    endtask

    // main sequence
    initial begin
        t_class_list plan;
        int unsigned phase_items;
        int unsigned len;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lists: extremes of key and class, short lists, every pattern
        send_request('0, '0, 1'b1);
        send_request('1, '1, 1'b0);
        send_request('1, '1, 1'b1);
        n_lists += 2;
        plan = '{12'h555, 12'hAAA, 12'h555};
        send_list(plan);
        plan = '{12'h555, 12'hAAA, 12'h555, 12'hAAA};
        send_list(plan);
        plan = '{12'h0F0, 12'h00F, 12'h0F0, 12'h00F, 12'h0F0};
        send_list(plan);
        plan = '{12'h321, 12'h321, 12'h654, 12'h321};
        send_list(plan);
        plan = '{12'h123, 12'h456, 12'h123, 12'h789, 12'h123, 12'h123};
        send_list(plan);

        // random lists under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            phase_items = 0;
            while (phase_items < RAND_ITEMS / 4) begin
                send_random_list(len);
                phase_items += len;
            end
        end
        i_in_valid <= 1'b0;

        // drain, once the last request has been noted
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d lists, %0d requests, %0d results (%0d kept, %0d dropped)",
                 n_lists, sb.n_requests, sb.n_results, sb.n_kept,
                 sb.n_results - sb.n_kept);
        $display("idling: none, sender only, receiver only, both");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("label_run_singleton_filter_top: match");
        end else begin
            $display("label_run_singleton_filter_top: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("label_run_singleton_filter_top: mismatch");
        $finish;
    end

endmodule
